[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
   `ASSERT_PROP(lbl, clk, rst, !(cond))

`else

`define ASSERT_PROP(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

[hw/rtl/hdc_pkg.sv]
package hdc_pkg;

   localparam int unsigned CSR_AW = 3;

   localparam logic REG_MOUSE    = 1'b0;
   localparam logic REG_KEYBOARD = 1'b1;

   localparam logic [31:0] MOUSE_CODE_RESET    = 32'h0001_0002;
   localparam logic [31:0] KEYBOARD_CODE_RESET = 32'h0001_0006;

   localparam logic [1:0] TYPE_MAIN   = 2'd0;
   localparam logic [1:0] TYPE_GLOBAL = 2'd1;
   localparam logic [1:0] TYPE_LOCAL  = 2'd2;

   localparam logic [3:0] TAG_LONG       = 4'hF;
   localparam logic [3:0] TAG_USAGE_PAGE = 4'h0;
   localparam logic [3:0] TAG_USAGE      = 4'h0;
   localparam logic [3:0] TAG_INPUT      = 4'h8;
   localparam logic [3:0] TAG_OUTPUT     = 4'h9;
   localparam logic [3:0] TAG_BEGIN_COLL = 4'hA;

   localparam logic [1:0] SIZE_NONE = 2'd0;
   localparam logic [1:0] SIZE_FOUR = 2'd3;

   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_MOUSE    = 2'd1;
   localparam logic [1:0] KIND_KEYBOARD = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
   localparam logic [1:0] STATUS_SHORT   = 2'd2;

   localparam logic [1:0] TALLY_FULL = 2'd2;

   typedef struct packed {
      logic [31:0] mouse_usage_code;
      logic [31:0] keyboard_usage_code;
   } cfg_type;

   typedef struct packed {
      logic [7:0] desc_byte;
      logic       is_last;
   } step_type;

   typedef struct packed {
      logic [1:0] device_kind;
      logic [1:0] status;
   } result_type;

endpackage

[hw/rtl/hdc_chan_if.sv]
interface hdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] desc_byte;
   logic       is_last;

   modport source (output valid, output desc_byte, output is_last, input ready);
   modport sink   (input valid, input desc_byte, input is_last, output ready);
endinterface

interface hdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] device_kind;
   logic [1:0] status;

   modport source (output valid, output device_kind, output status, input ready);
   modport sink   (input valid, input device_kind, input status, output ready);
endinterface

[hw/rtl/hdc_csr.sv]
module hdc_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [hdc_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output hdc_pkg::cfg_type           cfg
);

   hdc_pkg::cfg_type cfg_ff;
   hdc_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[2])
            hdc_pkg::REG_MOUSE:    cfg_in.mouse_usage_code    = pwdata;
            hdc_pkg::REG_KEYBOARD: cfg_in.keyboard_usage_code = pwdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         hdc_pkg::REG_MOUSE:    prdata = cfg_ff.mouse_usage_code;
         hdc_pkg::REG_KEYBOARD: prdata = cfg_ff.keyboard_usage_code;
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mouse_usage_code    <= hdc_pkg::MOUSE_CODE_RESET;
         cfg_ff.keyboard_usage_code <= hdc_pkg::KEYBOARD_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/hdc_parser.sv]
`include "assert_macros.svh"

module hdc_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_vld,
   input  hdc_pkg::step_type    step,
   input  hdc_pkg::cfg_type     cfg,
   output hdc_pkg::result_type  result
);

   typedef enum logic [4:0] {
      PH_HEADER     = 5'b00001,
      PH_SHORT_DATA = 5'b00010,
      PH_LONG_SIZE  = 5'b00100,
      PH_LONG_TAG   = 5'b01000,
      PH_LONG_DATA  = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  rem_ff, rem_in;
   logic [1:0]  type_ff, type_in;
   logic [3:0]  tag_ff, tag_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  lane_ff, lane_in;
   logic [15:0] page_ff, page_in;
   logic [31:0] usage_ff, usage_in;
   logic        det_ff, det_in;
   logic [1:0]  kind_ff, kind_in;
   logic        saw_in_ff, saw_in_in;
   logic        saw_out_ff, saw_out_in;
   logic [1:0]  tally_ff, tally_in;

   logic        fin;
   logic [1:0]  fin_type;
   logic [3:0]  fin_tag;
   logic [31:0] fin_data;
   logic [7:0]  rem_dec;
   logic [7:0]  b;

   assign b       = step.desc_byte;
   assign rem_dec = (rem_ff != 8'd0) ? rem_ff - 8'd1 : rem_ff;

   always_comb begin
      phase_in   = phase_ff;
      rem_in     = rem_ff;
      type_in    = type_ff;
      tag_in     = tag_ff;
      acc_in     = acc_ff;
      lane_in    = lane_ff;
      page_in    = page_ff;
      usage_in   = usage_ff;
      det_in     = det_ff;
      kind_in    = kind_ff;
      saw_in_in  = saw_in_ff;
      saw_out_in = saw_out_ff;
      tally_in   = (tally_ff == hdc_pkg::TALLY_FULL) ? tally_ff : tally_ff + 2'd1;
      fin        = 1'b0;
      fin_type   = type_ff;
      fin_tag    = tag_ff;
      fin_data   = '0;
      result     = '0;

      unique case (phase_ff)
         PH_HEADER: begin
            type_in  = b[3:2];
            tag_in   = b[7:4];
            acc_in   = '0;
            lane_in  = '0;
            fin_type = b[3:2];
            fin_tag  = b[7:4];
            if (b[7:4] == hdc_pkg::TAG_LONG) begin
               phase_in = PH_LONG_SIZE;
            end else if (b[1:0] == hdc_pkg::SIZE_NONE) begin
               fin = 1'b1;
            end else begin
               rem_in   = (b[1:0] == hdc_pkg::SIZE_FOUR) ? 8'd4 : {6'd0, b[1:0]};
               phase_in = PH_SHORT_DATA;
            end
         end
         PH_SHORT_DATA: begin
            acc_in   = acc_ff | ({24'd0, b} << {lane_ff, 3'b000});
            lane_in  = lane_ff + 2'd1;
            rem_in   = rem_dec;
            fin_data = acc_ff | ({24'd0, b} << {lane_ff, 3'b000});
            if (rem_dec == 8'd0) begin
               fin      = 1'b1;
               phase_in = PH_HEADER;
            end
         end
         PH_LONG_SIZE: begin
            rem_in   = b;
            phase_in = PH_LONG_TAG;
         end
         PH_LONG_TAG: begin
            phase_in = (rem_ff != 8'd0) ? PH_LONG_DATA : PH_HEADER;
         end
         PH_LONG_DATA: begin
            rem_in = rem_dec;
            if (rem_dec == 8'd0) begin
               phase_in = PH_HEADER;
            end
         end
         default: phase_in = PH_HEADER;
      endcase

      if (fin) begin
         if (fin_type == hdc_pkg::TYPE_MAIN) begin
            if (fin_tag == hdc_pkg::TAG_INPUT) begin
               saw_in_in = 1'b1;
            end else if (fin_tag == hdc_pkg::TAG_OUTPUT) begin
               saw_out_in = 1'b1;
            end
         end
         if (!det_ff) begin
            if (fin_type == hdc_pkg::TYPE_GLOBAL && fin_tag == hdc_pkg::TAG_USAGE_PAGE) begin
               page_in = fin_data[15:0];
            end else if (fin_type == hdc_pkg::TYPE_LOCAL && fin_tag == hdc_pkg::TAG_USAGE) begin
               usage_in = {page_ff, 16'd0} | fin_data;
            end else if (fin_type == hdc_pkg::TYPE_MAIN &&
                         fin_tag == hdc_pkg::TAG_BEGIN_COLL) begin
               if (usage_ff == cfg.mouse_usage_code) begin
                  det_in  = 1'b1;
                  kind_in = hdc_pkg::KIND_MOUSE;
               end else if (usage_ff == cfg.keyboard_usage_code) begin
                  det_in  = 1'b1;
                  kind_in = hdc_pkg::KIND_KEYBOARD;
               end
            end
         end
      end

      if (tally_in != hdc_pkg::TALLY_FULL) begin
         result.device_kind = hdc_pkg::KIND_NONE;
         result.status      = hdc_pkg::STATUS_SHORT;
      end else if (det_in) begin
         result.device_kind = kind_in;
         result.status      = hdc_pkg::STATUS_OK;
      end else if (saw_in_in && saw_out_in) begin
         result.device_kind = hdc_pkg::KIND_KEYBOARD;
         result.status      = hdc_pkg::STATUS_OK;
      end else if (saw_in_in) begin
         result.device_kind = hdc_pkg::KIND_MOUSE;
         result.status      = hdc_pkg::STATUS_OK;
      end else begin
         result.device_kind = hdc_pkg::KIND_NONE;
         result.status      = hdc_pkg::STATUS_UNKNOWN;
      end

      // clear for the next descriptor
      if (step.is_last) begin
         phase_in   = PH_HEADER;
         rem_in     = '0;
         type_in    = '0;
         tag_in     = '0;
         acc_in     = '0;
         lane_in    = '0;
         page_in    = '0;
         usage_in   = '0;
         det_in     = 1'b0;
         kind_in    = hdc_pkg::KIND_NONE;
         saw_in_in  = 1'b0;
         saw_out_in = 1'b0;
         tally_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         rem_ff     <= '0;
         type_ff    <= '0;
         tag_ff     <= '0;
         acc_ff     <= '0;
         lane_ff    <= '0;
         page_ff    <= '0;
         usage_ff   <= '0;
         det_ff     <= 1'b0;
         kind_ff    <= hdc_pkg::KIND_NONE;
         saw_in_ff  <= 1'b0;
         saw_out_ff <= 1'b0;
         tally_ff   <= '0;
      end else if (step_vld) begin
         phase_ff   <= phase_in;
         rem_ff     <= rem_in;
         type_ff    <= type_in;
         tag_ff     <= tag_in;
         acc_ff     <= acc_in;
         lane_ff    <= lane_in;
         page_ff    <= page_in;
         usage_ff   <= usage_in;
         det_ff     <= det_in;
         kind_ff    <= kind_in;
         saw_in_ff  <= saw_in_in;
         saw_out_ff <= saw_out_in;
         tally_ff   <= tally_in;
      end
   end

   `ASSERT_PROP(a_clear_after_last, clock, reset, step_vld && step.is_last |=> phase_ff == PH_HEADER && tally_ff == 2'd0 && !det_ff)
   `ASSERT_PROP(a_tally_sticky, clock, reset, tally_ff == hdc_pkg::TALLY_FULL && !(step_vld && step.is_last) |=> tally_ff == hdc_pkg::TALLY_FULL)
   `ASSERT_PROP(a_detect_sticky, clock, reset, det_ff && !(step_vld && step.is_last) |=> det_ff && $stable(kind_ff))

endmodule

[hw/rtl/hid_descriptor_device_classifier_unit.sv]
// Channel | Dir | Payload                | Handshake
// req     | in  | desc_byte, is_last     | valid/ready
// rsp     | out | device_kind, status    | valid/ready
// csr     | in  | two 32-bit code regs   | APB, pready tied high
//
// One byte per cycle sustained while the input does not stall; each beat passes through the input register.
// A result beat is registered in the response register when its last byte leaves the input register.
// Reset is synchronous and clears the parse state and restores the code registers.
// The input stalls only while a last byte waits in the input register behind
// a result beat that has not been taken.
`include "assert_macros.svh"

module hid_descriptor_device_classifier_unit (
   input  logic                       clock,
   input  logic                       reset,
   hdc_req_if.sink                    req_chan,
   hdc_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [hdc_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   hdc_pkg::cfg_type    cfg;
   hdc_pkg::step_type   in_beat_ff, in_beat_in;
   logic                in_vld_ff, in_vld_in;
   hdc_pkg::result_type result;
   hdc_pkg::result_type rsp_beat_ff, rsp_beat_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic                advance;
   logic                take;

   hdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hdc_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step_vld (advance),
      .step     (in_beat_ff),
      .cfg      (cfg),
      .result   (result)
   );

   assign advance = in_vld_ff && (!in_beat_ff.is_last || !rsp_vld_ff || rsp_chan.ready);
   assign take    = req_chan.valid && req_chan.ready;

   assign req_chan.ready       = !in_vld_ff || advance;
   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.device_kind = rsp_beat_ff.device_kind;
   assign rsp_chan.status      = rsp_beat_ff.status;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_beat_in = in_beat_ff;
      if (take) begin
         in_vld_in            = 1'b1;
         in_beat_in.desc_byte = req_chan.desc_byte;
         in_beat_in.is_last   = req_chan.is_last;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_beat_in = rsp_beat_ff;
      if (advance && in_beat_ff.is_last) begin
         rsp_vld_in  = 1'b1;
         rsp_beat_in = result;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_beat_ff  <= in_beat_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   `ASSERT_PROP(a_last_loads_rsp, clock, reset, advance && in_beat_ff.is_last |=> rsp_vld_ff)
   `ASSERT_PROP(a_rsp_from_last, clock, reset, $rose(rsp_vld_ff) |-> $past(advance && in_beat_ff.is_last))
   `ASSERT_PROP(a_only_last_stalls, clock, reset, in_vld_ff && !advance |-> in_beat_ff.is_last && rsp_vld_ff)

endmodule
